// ===== sv/ordered_value_list_engine_top_macros.svh =====
// ----------------------------------------------------------------------------
// Ordered value list engine assertion macros
// Shared property forms for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef ORDERED_VALUE_LIST_ENGINE_TOP_MACROS_SVH
`define ORDERED_VALUE_LIST_ENGINE_TOP_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset
`define OVLE_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ordered value list engine: same-cycle check failed");

// Next-cycle implication, sampled on clock, off during reset
`define OVLE_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ordered value list engine: next-cycle check failed");

`endif

// ===== sv/ovl_pkg.sv =====
// ----------------------------------------------------------------------------
// Ordered value list package
// Sizes, codes and the control bundle shared by the list cells and the top.
// ----------------------------------------------------------------------------
`default_nettype none

package ovl_pkg;

   // List depth and derived widths
   localparam int CAPACITY = 16;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   // Fixed field widths of the ports
   localparam int DATA_W  = 32;
   localparam int CMD_W   = 2;
   localparam int STAT_W  = 2;
   localparam int POS_W   = 4;
   localparam int ENTRY_W = 5;

   typedef enum logic [CMD_W-1:0] {
      CMD_APPEND = 2'd0,
      CMD_INSERT = 2'd1,
      CMD_DELETE = 2'd2,
      CMD_READ   = 2'd3
   } ovl_cmd_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK        = 2'd0,
      STAT_EMPTY     = 2'd1,
      STAT_NOT_FOUND = 2'd2,
      STAT_FULL      = 2'd3
   } ovl_status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_READ
   } ovl_state_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_APPEND,
      CELL_INSERT,
      CELL_DELETE,
      CELL_ROTATE
   } ovl_cell_op_type;

   // Broadcast from the sequencer to every cell
   typedef struct packed {
      ovl_cell_op_type          op;
      logic [CNT_W-1:0]         count;
      logic signed [DATA_W-1:0] new_value;
      logic signed [DATA_W-1:0] match_key;
   } ovl_cell_ctl_type;

endpackage

`default_nettype wire

// ===== sv/ovl_cell.sv =====
// ----------------------------------------------------------------------------
// Ordered value list cell
// Holds one list entry, compares it with the key and moves data to or from
// its neighbors on insert, delete and read-out rotation.
// ----------------------------------------------------------------------------
`default_nettype none

module ovl_cell
   import ovl_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic [IDX_W-1:0]         cell_index,
   input  wire ovl_cell_ctl_type         ctl,
   input  wire logic signed [DATA_W-1:0] prev_value,
   input  wire logic signed [DATA_W-1:0] next_value,
   input  wire logic signed [DATA_W-1:0] head_value,
   input  wire logic                     seen_in,
   output logic                          seen_out,
   output logic signed [DATA_W-1:0]      value
);

   logic signed [DATA_W-1:0] value_ff;
   logic signed [DATA_W-1:0] value_in;
   logic                     in_use;
   logic                     at_tail;
   logic                     is_last;
   logic                     hit;

   // Position of this cell relative to the fill level
   assign in_use  = CNT_W'(cell_index) < ctl.count;
   assign at_tail = CNT_W'(cell_index) == ctl.count;
   assign is_last = (CNT_W'(cell_index) + CNT_W'(1)) == ctl.count;

   // Match and pass the first-match marker down the row
   assign hit      = in_use && (value_ff == ctl.match_key);
   assign seen_out = seen_in | hit;
   assign value    = value_ff;

   // Select the new entry value
   always_comb begin
      value_in = value_ff;
      case (ctl.op)
         CELL_APPEND: begin
            if (at_tail) value_in = ctl.new_value;
         end
         CELL_INSERT: begin
            if (hit && !seen_in) begin
               value_in = ctl.new_value;
            end else if (seen_in && (in_use || at_tail)) begin
               value_in = prev_value;
            end
         end
         CELL_DELETE: begin
            if ((hit || seen_in) && in_use) value_in = next_value;
         end
         CELL_ROTATE: begin
            if (is_last) begin
               value_in = head_value;
            end else if (in_use) begin
               value_in = next_value;
            end
         end
         default: value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

`default_nettype wire

// ===== sv/ordered_value_list_engine_top.sv =====
// Ordered value list engine: each append, insert or delete command passes
// through an accept step, then an execute step across the row of cells.
// Read-out: execute step, then one result per entry per cycle while the output
// is not stalled, set by the one-step rotation of the cell row through the head cell.
// A finished result waits in the output register; the next command is taken
// once that register is loaded. Synchronous reset empties the list at once.
// ----------------------------------------------------------------------------
// Ordered value list engine top level
// Command sequencer, row of list cells and registered result channel.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ordered_value_list_engine_top_macros.svh"

module ordered_value_list_engine_top
   import ovl_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic [CMD_W-1:0]          req_command,
   input  wire logic signed [DATA_W-1:0]  req_new_value,
   input  wire logic signed [DATA_W-1:0]  req_match_key,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic [STAT_W-1:0]              rsp_status,
   output logic signed [DATA_W-1:0]       rsp_item_value,
   output logic [POS_W-1:0]               rsp_item_position,
   output logic                           rsp_last_item,
   output logic [ENTRY_W-1:0]             rsp_entry_count
);

   ovl_state_type            state_ff, state_in;
   ovl_cmd_type              cmd_ff;
   logic signed [DATA_W-1:0] new_value_ff;
   logic signed [DATA_W-1:0] key_ff;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [IDX_W-1:0]         pos_ff, pos_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   ovl_status_type           rsp_status_ff, rsp_status_in;
   logic signed [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic [POS_W-1:0]         rsp_pos_ff, rsp_pos_in;
   logic                     rsp_last_ff, rsp_last_in;
   logic [ENTRY_W-1:0]       rsp_count_ff;
   logic                     rsp_load;

   logic                     req_take;
   logic                     out_free;
   logic                     list_full;
   logic                     list_empty;
   logic                     key_found;
   logic                     last_read;

   ovl_cell_op_type          cell_op;
   ovl_cell_ctl_type         cell_ctl;
   logic signed [DATA_W-1:0] cell_value [CAPACITY];
   logic                     seen_chain [CAPACITY+1];

   // Handshake status
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_take   = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign list_full  = (count_ff == CNT_W'(CAPACITY));
   assign list_empty = (count_ff == '0);
   assign key_found  = seen_chain[CAPACITY];
   assign last_read  = (CNT_W'(pos_ff) + CNT_W'(1)) == count_ff;

   // Broadcast to the cell row
   assign cell_ctl.op        = cell_op;
   assign cell_ctl.count     = count_ff;
   assign cell_ctl.new_value = new_value_ff;
   assign cell_ctl.match_key = key_ff;

   // Row of list cells, head at index 0
   assign seen_chain[0] = 1'b0;
   for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic signed [DATA_W-1:0] prev_v;
      logic signed [DATA_W-1:0] next_v;
      if (gi == 0) begin : g_head
         assign prev_v = '0;
      end else begin : g_body
         assign prev_v = cell_value[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_tail
         assign next_v = '0;
      end else begin : g_inner
         assign next_v = cell_value[gi+1];
      end
      ovl_cell u_cell (
         .clock      (clock),
         .cell_index (IDX_W'(gi)),
         .ctl        (cell_ctl),
         .prev_value (prev_v),
         .next_value (next_v),
         .head_value (cell_value[0]),
         .seen_in    (seen_chain[gi]),
         .seen_out   (seen_chain[gi+1]),
         .value      (cell_value[gi])
      );
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (out_free) begin
               if (cmd_ff == CMD_READ && !list_empty) begin
                  state_in = ST_READ;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_READ: begin
            if (out_free && last_read) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs: cell operation, count update and result load
   always_comb begin
      cell_op       = CELL_HOLD;
      count_in      = count_ff;
      pos_in        = pos_ff;
      rsp_load      = 1'b0;
      rsp_status_in = STAT_OK;
      rsp_value_in  = '0;
      rsp_pos_in    = '0;
      rsp_last_in   = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            pos_in = '0;
         end
         ST_EXEC: begin
            if (out_free) begin
               rsp_load = 1'b1;
               unique case (cmd_ff)
                  CMD_APPEND: begin
                     if (list_full) begin
                        rsp_status_in = STAT_FULL;
                     end else begin
                        cell_op  = CELL_APPEND;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  CMD_INSERT: begin
                     if (list_empty) begin
                        rsp_status_in = STAT_EMPTY;
                     end else if (list_full) begin
                        rsp_status_in = STAT_FULL;
                     end else if (!key_found) begin
                        rsp_status_in = STAT_NOT_FOUND;
                     end else begin
                        cell_op  = CELL_INSERT;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  CMD_DELETE: begin
                     if (list_empty) begin
                        rsp_status_in = STAT_EMPTY;
                     end else if (!key_found) begin
                        rsp_status_in = STAT_NOT_FOUND;
                     end else begin
                        cell_op  = CELL_DELETE;
                        count_in = count_ff - CNT_W'(1);
                     end
                  end
                  CMD_READ: begin
                     pos_in = '0;
                     if (list_empty) begin
                        rsp_status_in = STAT_EMPTY;
                     end else begin
                        rsp_load = 1'b0;
                     end
                  end
                  default: rsp_status_in = STAT_OK;
               endcase
            end
         end
         ST_READ: begin
            if (out_free) begin
               rsp_load     = 1'b1;
               rsp_value_in = cell_value[0];
               rsp_pos_in   = POS_W'(pos_ff);
               rsp_last_in  = last_read;
               cell_op      = CELL_ROTATE;
               pos_in       = pos_ff + IDX_W'(1);
            end
         end
         default: cell_op = CELL_HOLD;
      endcase
   end

   // Result valid: set on load, drop after the transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the accepted command
   always_ff @(posedge clock) begin
      if (req_take) begin
         cmd_ff       <= ovl_cmd_type'(req_command);
         new_value_ff <= req_new_value;
         key_ff       <= req_match_key;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_value_ff  <= rsp_value_in;
         rsp_pos_ff    <= rsp_pos_in;
         rsp_last_ff   <= rsp_last_in;
         rsp_count_ff  <= ENTRY_W'(count_in);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_item_value    = rsp_value_ff;
   assign rsp_item_position = rsp_pos_ff;
   assign rsp_last_item     = rsp_last_ff;
   assign rsp_entry_count   = rsp_count_ff;

   // Checks
   `OVLE_ASSERT_SAME(a_count_bound, 1'b1, count_ff <= CNT_W'(CAPACITY))
   `OVLE_ASSERT_SAME(a_read_nonempty, state_ff == ST_READ, count_ff != '0)
   `OVLE_ASSERT_NEXT(a_take_exec, req_take, state_ff == ST_EXEC)
   `OVLE_ASSERT_NEXT(a_load_valid, rsp_load, rsp_valid_ff)

endmodule

`default_nettype wire
